// ===== src/rssnh_pkg.sv =====
// Package for the segment / sphere-set nearest hit block.
// Holds the request command type and shared constants; no dependencies.
package rssnh_pkg;

   // reset value of the radius register, 0.2 in Q5.16
   localparam logic [20:0] RADIUS_RESET = 21'd13107;
   // 1.0 in Q1.16
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_CAST  = 1'b1;

   // shift codes for the shared multiplier's accumulate path
   typedef enum logic [1:0] {
      SH_0  = 2'd0,
      SH_27 = 2'd1,
      SH_52 = 2'd2
   } shift_type;

   // classified request as it sits in the queue
   typedef struct packed {
      logic               is_cast;
      logic               idx_ok;
      logic [8:0]         idx;
      logic               valid;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
      logic [16:0]        ratio;
   } cmd_type;

endpackage

// ===== src/rssnh_front.sv =====
// Front end: takes requests, classifies them and queues them (two deep).
// Depends on rssnh_pkg.
module rssnh_front import rssnh_pkg::*; #(
   parameter int NUM_SPHERES = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic [8:0]         req_entry_index,
   input  logic               req_entry_valid,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic [16:0]        req_start_ratio,
   input  logic               clearing,
   output logic               head_valid,
   output cmd_type            head,
   input  logic               pop
);

   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push;
   cmd_type    cmd;

   // classify the incoming request
   always_comb begin
      cmd.is_cast  = (req_type == REQ_CAST);
      cmd.idx_ok   = ({4'd0, req_entry_index} < 13'(NUM_SPHERES));
      cmd.idx      = req_entry_index;
      cmd.valid    = req_entry_valid;
      cmd.ax       = req_a_x;
      cmd.ay       = req_a_y;
      cmd.az       = req_a_z;
      cmd.bx       = req_b_x;
      cmd.by       = req_b_y;
      cmd.bz       = req_b_z;
      cmd.ratio    = req_start_ratio;
   end

   assign busy       = (cnt_ff == 2'd2) || clearing;
   assign push       = start && !busy;
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[rp_ff];

   // queue pointers
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cmd;
      end
   end

endmodule

// ===== src/rssnh_back.sv =====
// Back end: sphere table, scan sequencer, shared multiplier and divider.
// Depends on rssnh_pkg.
module rssnh_back import rssnh_pkg::*; #(
   parameter int NUM_SPHERES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  cmd_type     head,
   output logic        pop,
   input  logic [20:0] radius,
   output logic        clearing,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [16:0] rsp_hit_ratio
);

   localparam int AW = (NUM_SPHERES > 1) ? $clog2(NUM_SPHERES) : 1;
   localparam logic [AW-1:0] LAST = AW'(NUM_SPHERES - 1);

   typedef enum logic [14:0] {
      S_CLEAR = 15'b000000000000001,
      S_IDLE  = 15'b000000000000010,
      S_LEN   = 15'b000000000000100,
      S_LCHK  = 15'b000000000001000,
      S_RD    = 15'b000000000010000,
      S_BOX   = 15'b000000000100000,
      S_DOT   = 15'b000000001000000,
      S_CHKP  = 15'b000000010000000,
      S_DIV   = 15'b000000100000000,
      S_TCHK  = 15'b000001000000000,
      S_UMUL  = 15'b000010000000000,
      S_SQ    = 15'b000100000000000,
      S_CMP   = 15'b001000000000000,
      S_NEXT  = 15'b010000000000000,
      S_DONE  = 15'b100000000000000
   } state_type;

   function automatic logic [32:0] abs33(logic signed [32:0] v);
      abs33 = v[32] ? 33'(-v) : v;
   endfunction

   state_type state_ff, state_in;
   logic [AW-1:0] sc_ff, sc_in;
   logic [4:0]    iss_ff, iss_in;
   logic [1:0]    ax_ff, ax_in, pt_ff, pt_in;

   // table
   logic [96:0] mem [NUM_SPHERES];
   logic [96:0] mem_q_ff;

   // cast context
   logic signed [31:0] a_ff [3];
   logic signed [31:0] b_ff [3];
   logic signed [32:0] d_ff [3];
   logic signed [32:0] w_ff [3];
   logic signed [50:0] u_ff [3];
   logic [16:0]        best_ff;
   logic [73:0]        lim_ff;
   logic [65:0]        len_ff;
   logic [16:0]        t_ff;
   logic [67:0]        rem_ff;
   logic signed [103:0] acc_ff;

   // multiplier pipe
   logic [67:0] prod_ff;
   logic        pneg_ff, pdst_ff, pv_ff;
   logic [1:0]  psh_ff, pax_ff;
   logic [33:0] mul_a, mul_b;
   logic        mul_neg, mul_dst, issue;
   shift_type   mul_sh;
   logic [1:0]  mul_ax;

   logic rsp_valid_ff, rsp_hit_ff;
   logic [16:0] rsp_ratio_ff;

   logic signed [31:0] c_v [3];
   logic        miss;
   logic [1:0]  axi;
   logic [50:0] uabs;
   logic [103:0] ext;
   logic signed [103:0] sprod;
   logic [50:0] up;
   logic [67:0] rs;
   logic        ge;
   logic        wr_cmd;

   assign clearing = (state_ff == S_CLEAR);
   assign pop      = (state_ff == S_IDLE) && head_valid;
   assign wr_cmd   = pop && !head.is_cast && head.idx_ok;
   assign axi      = (iss_ff[1:0] == 2'd3) ? 2'd0 : iss_ff[1:0];

   assign c_v[0] = mem_q_ff[95:64];
   assign c_v[1] = mem_q_ff[63:32];
   assign c_v[2] = mem_q_ff[31:0];

   // box test, all axes
   always_comb begin
      logic signed [33:0] c34, r34, lo, hi, p34, q34;
      miss = 1'b0;
      r34  = {13'd0, radius};
      for (int k = 0; k < 3; k++) begin
         c34 = 34'(c_v[k]);
         p34 = 34'(a_ff[k]);
         q34 = 34'(b_ff[k]);
         lo  = (p34 < q34) ? p34 : q34;
         hi  = (p34 > q34) ? p34 : q34;
         if ((c34 + r34 < lo) || (c34 - r34 > hi)) begin
            miss = 1'b1;
         end
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      uabs    = u_ff[ax_ff][50] ? 51'(-u_ff[ax_ff]) : u_ff[ax_ff];
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      mul_sh  = SH_0;
      mul_dst = 1'b0;
      mul_ax  = axi;
      issue   = 1'b0;
      case (state_ff)
         S_LEN: begin
            issue = (iss_ff < 5'd3);
            mul_a = {1'b0, abs33(d_ff[axi])};
            mul_b = {1'b0, abs33(d_ff[axi])};
         end
         S_DOT: begin
            issue   = (iss_ff < 5'd3);
            mul_a   = {1'b0, abs33(d_ff[axi])};
            mul_b   = {1'b0, abs33(w_ff[axi])};
            mul_neg = d_ff[axi][32] ^ w_ff[axi][32];
         end
         S_UMUL: begin
            issue   = (iss_ff < 5'd3);
            mul_a   = {1'b0, abs33(d_ff[axi])};
            mul_b   = {17'd0, t_ff};
            mul_neg = d_ff[axi][32];
            mul_dst = 1'b1;
         end
         S_SQ: begin
            issue = (iss_ff < 5'd9);
            case (pt_ff)
               2'd0: begin
                  mul_a  = {9'd0, uabs[50:26]};
                  mul_b  = {9'd0, uabs[50:26]};
                  mul_sh = SH_52;
               end
               2'd1: begin
                  mul_a  = {9'd0, uabs[50:26]};
                  mul_b  = {8'd0, uabs[25:0]};
                  mul_sh = SH_27;
               end
               default: begin
                  mul_a  = {8'd0, uabs[25:0]};
                  mul_b  = {8'd0, uabs[25:0]};
                  mul_sh = SH_0;
               end
            endcase
         end
         default: issue = 1'b0;
      endcase
   end

   // product alignment
   always_comb begin
      case (shift_type'(psh_ff))
         SH_27:   ext = {36'd0, prod_ff} << 27;
         SH_52:   ext = {36'd0, prod_ff} << 52;
         default: ext = {36'd0, prod_ff};
      endcase
      sprod = pneg_ff ? -$signed(ext) : $signed(ext);
      up    = pneg_ff ? 51'(-prod_ff[50:0]) : prod_ff[50:0];
   end

   // divider step
   always_comb begin
      rs = (iss_ff == 5'd0) ? rem_ff : {rem_ff[66:0], 1'b0};
      ge = (rs >= {2'd0, len_ff});
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      sc_in    = sc_ff;
      iss_in   = iss_ff;
      ax_in    = ax_ff;
      pt_in    = pt_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sc_ff == LAST) begin
               sc_in    = '0;
               state_in = S_IDLE;
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (head_valid && head.is_cast) begin
               iss_in   = '0;
               state_in = S_LEN;
            end
         end
         S_LEN, S_DOT: begin
            iss_in = iss_ff + 1'b1;
            if (iss_ff == 5'd3) begin
               state_in = (state_ff == S_LEN) ? S_LCHK : S_CHKP;
            end
         end
         S_LCHK: begin
            sc_in    = '0;
            state_in = (acc_ff == '0) ? S_DONE : S_RD;
         end
         S_RD: state_in = S_BOX;
         S_BOX: begin
            iss_in   = '0;
            state_in = (!mem_q_ff[96] || miss) ? S_NEXT : S_DOT;
         end
         S_CHKP: begin
            iss_in   = '0;
            state_in = (acc_ff[103] || (acc_ff > $signed({38'd0, len_ff}))) ?
                       S_NEXT : S_DIV;
         end
         S_DIV: begin
            iss_in = iss_ff + 1'b1;
            if (iss_ff == 5'd16) begin
               state_in = S_TCHK;
            end
         end
         S_TCHK: begin
            iss_in   = '0;
            state_in = (t_ff >= best_ff) ? S_NEXT : S_UMUL;
         end
         S_UMUL: begin
            iss_in = iss_ff + 1'b1;
            ax_in  = '0;
            pt_in  = '0;
            if (iss_ff == 5'd3) begin
               iss_in   = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            iss_in = iss_ff + 1'b1;
            if (issue) begin
               if (pt_ff == 2'd2) begin
                  pt_in = '0;
                  ax_in = ax_ff + 1'b1;
               end else begin
                  pt_in = pt_ff + 1'b1;
               end
            end
            if (iss_ff == 5'd9) begin
               state_in = S_CMP;
            end
         end
         S_CMP: state_in = S_NEXT;
         S_NEXT: begin
            if (sc_ff == LAST) begin
               state_in = S_DONE;
            end else begin
               sc_in    = sc_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sc_ff        <= '0;
         iss_ff       <= '0;
         ax_ff        <= '0;
         pt_ff        <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sc_ff        <= sc_in;
         iss_ff       <= iss_in;
         ax_ff        <= ax_in;
         pt_ff        <= pt_in;
         pv_ff        <= issue;
         rsp_valid_ff <= (state_ff == S_DONE);
      end
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         mem[sc_ff] <= '0;
      end else if (wr_cmd) begin
         mem[AW'(head.idx)] <= {head.valid, head.ax, head.ay, head.az};
      end
      mem_q_ff <= mem[sc_ff];
   end

   // multiplier stage
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      pneg_ff <= mul_neg;
      psh_ff  <= mul_sh;
      pdst_ff <= mul_dst;
      pax_ff  <= mul_ax;
   end

   // datapath
   always_ff @(posedge clock) begin
      // cast setup
      if (pop && head.is_cast) begin
         a_ff[0] <= head.ax;
         a_ff[1] <= head.ay;
         a_ff[2] <= head.az;
         b_ff[0] <= head.bx;
         b_ff[1] <= head.by;
         b_ff[2] <= head.bz;
         d_ff[0] <= 33'(head.bx) - 33'(head.ax);
         d_ff[1] <= 33'(head.by) - 33'(head.ay);
         d_ff[2] <= 33'(head.bz) - 33'(head.az);
         best_ff <= head.ratio;
         lim_ff  <= {32'd0, 42'(radius * radius)} << 32;
      end
      if (state_ff == S_LCHK) begin
         len_ff <= acc_ff[65:0];
      end
      // offsets from segment start
      if (state_ff == S_BOX) begin
         for (int k = 0; k < 3; k++) begin
            w_ff[k] <= 33'(c_v[k]) - 33'(a_ff[k]);
         end
      end
      // accumulator
      if ((pop && head.is_cast) || (state_ff == S_BOX) ||
          (state_ff == S_UMUL && iss_ff == 5'd3)) begin
         acc_ff <= '0;
      end else if (pv_ff && !pdst_ff) begin
         acc_ff <= acc_ff + sprod;
      end
      // offset from projected point, scaled by 2^16
      if (pv_ff && pdst_ff) begin
         u_ff[pax_ff] <= $signed({w_ff[pax_ff][32], w_ff[pax_ff][32], w_ff[pax_ff], 16'd0})
                         - $signed(up);
      end
      // restoring divide, one quotient bit a cycle
      if (state_ff == S_CHKP) begin
         rem_ff <= acc_ff[67:0];
         t_ff   <= '0;
      end else if (state_ff == S_DIV) begin
         rem_ff <= ge ? rs - {2'd0, len_ff} : rs;
         t_ff   <= {t_ff[15:0], ge};
      end
      if (state_ff == S_CMP && (acc_ff < $signed({30'd0, lim_ff}))) begin
         best_ff <= t_ff;
      end
      if (state_ff == S_DONE) begin
         rsp_hit_ff   <= (best_ff < ONE_Q16);
         rsp_ratio_ff <= best_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_hit_ratio = rsp_ratio_ff;

`ifndef ASSERT_OFF
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TCHK) |-> (t_ff <= ONE_Q16))
      else $error("projection ratio above one");
   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && iss_ff == 5'd0) |-> (rem_ff <= {2'd0, len_ff}))
      else $error("dividend exceeds segment length");
   a_dist_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> !acc_ff[103])
      else $error("negative squared distance");
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pv_ff)
      else $error("product pending while idle");
`endif

endmodule

// ===== src/ray_sphere_set_nearest_hit.sv =====
// Segment against sphere-set nearest hit, top level: radius register, front, back.
// A write is stored when popped from the queue. A cast first sums the squared length,
// then per table entry reads it and skips it if invalid or a box miss, else runs dot
// product, divider and squared distance on the one shared multiplier; result registered.
// One request in service at a time; a two-deep queue takes new requests meanwhile.
// Reset: synchronous; a clearing pass over all NUM_SPHERES entries holds busy high.
module ray_sphere_set_nearest_hit import rssnh_pkg::*; #(
   parameter int NUM_SPHERES = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic [8:0]         req_entry_index,
   input  logic               req_entry_valid,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic [16:0]        req_start_ratio,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [16:0]        rsp_hit_ratio,
   input  logic               csr_we,
   input  logic [20:0]        csr_wdata
);

   logic [20:0] radius_ff;
   logic        head_valid, pop, clearing;
   cmd_type     head;

   // radius register
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_we) begin
         radius_ff <= csr_wdata;
      end
   end

   rssnh_front #(.NUM_SPHERES(NUM_SPHERES)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_entry_index(req_entry_index),
      .req_entry_valid(req_entry_valid),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z),
      .req_start_ratio(req_start_ratio), .clearing(clearing),
      .head_valid(head_valid), .head(head), .pop(pop)
   );

   rssnh_back #(.NUM_SPHERES(NUM_SPHERES)) u_back (
      .clock(clock), .reset(reset), .head_valid(head_valid), .head(head),
      .pop(pop), .radius(radius_ff), .clearing(clearing),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_hit_ratio(rsp_hit_ratio)
   );

endmodule
